// ===== rtl/adaptive_schmitt_period_tracker_macros.svh =====
// assertion macros for the adaptive schmitt period tracker checker
// needs a clk and rst signal in the scope where the macros are used
`ifndef ADAPTIVE_SCHMITT_PERIOD_TRACKER_MACROS_SVH
`define ADAPTIVE_SCHMITT_PERIOD_TRACKER_MACROS_SVH

// property that must hold at every edge out of reset
`define ASPT_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("aspt assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aspt assertion failed");

`endif

// ===== rtl/aspt_pkg.sv =====
// shared types and constants for the adaptive schmitt period tracker
// no dependencies
package aspt_pkg;

  localparam int ENV_FRAC_BITS    = 16;
  localparam int PERIOD_FRAC_BITS = 8;

  localparam int SAMPLE_W = 24;
  localparam int ENV_W    = 24 + ENV_FRAC_BITS;
  localparam int ENV_LO_W = ENV_W / 2;
  localparam int ENV_HI_W = ENV_W - ENV_LO_W;
  localparam int PERIOD_W = 20 + PERIOD_FRAC_BITS;
  localparam int HI_W     = 23;
  localparam int D_W      = 20;
  localparam int RATE_W   = 19;
  localparam int FLOOR_W  = 23;
  localparam int CFG_W    = 23;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W    = 32;
  localparam int IDX_W    = 64;

  // shared multiplier: a operand wide enough for a period or a sample magnitude
  localparam int MUL_A_W  = (PERIOD_W > SAMPLE_W) ? PERIOD_W : SAMPLE_W;
  localparam int COEF_W   = 16;
  localparam int SHIFT_W  = 5;
  localparam int ACC_W    = ((ENV_W > PERIOD_W) ? ENV_W : PERIOD_W) + 17;

  localparam logic [COEF_W-1:0] C_ENV_KEEP = 16'd65405;
  localparam logic [COEF_W-1:0] C_ENV_NEW  = 16'd131;
  localparam logic [COEF_W-1:0] C_HI       = 16'd22938;
  localparam logic [COEF_W-1:0] C_LO       = 16'd29491;
  localparam logic [COEF_W-1:0] C_PER_KEEP = 16'd55706;
  localparam logic [COEF_W-1:0] C_PER_NEW  = 16'd9830;

  localparam logic [PERIOD_W-1:0] PERIOD_ONE = PERIOD_W'(1) << PERIOD_FRAC_BITS;

  localparam logic [RATE_W-1:0]  RATE_RESET  = 19'd48000;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 23'd2500;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_FLOOR = 2'd1;

  localparam logic [1:0] LVL_MID  = 2'b00;
  localparam logic [1:0] LVL_HIGH = 2'b01;
  localparam logic [1:0] LVL_LOW  = 2'b11;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENV_L,
    S_ENV_H,
    S_ENV_M,
    S_HI_L,
    S_HI_H,
    S_LO,
    S_DECIDE,
    S_PER_X,
    S_PER_WB,
    S_OUT
  } state_t;

  typedef struct packed {
    logic               en;
    logic               clear;
    logic               rnd;
    logic [MUL_A_W-1:0] a;
    logic [COEF_W-1:0]  b;
    logic [SHIFT_W-1:0] shift;
  } mac_ctl_t;

endpackage

// ===== rtl/adaptive_schmitt_period_tracker.sv =====
// adaptive schmitt period tracker: one sample in, one result out
// out_valid in S_OUT, after S_ENV_L/H/M, S_HI_L/H, S_LO, S_DECIDE, S_PER_X/WB if smoothed
// one sample at a time: the next input is taken after the result transfer
// the sequence runs on the single shared multiply-accumulate unit, one product a cycle
// rst (synchronous) clears all tracking state and loads rate 48000 and floor 2500
module adaptive_schmitt_period_tracker import aspt_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        edge_res,
  output logic signed [1:0]           level,
  output logic [CNT_W-1:0]            edge_total,
  output logic [PERIOD_W-1:0]         period,
  output logic                        locked,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  // configuration registers
  logic [RATE_W-1:0]  sample_rate_hz;
  logic [FLOOR_W-1:0] threshold_floor;

  // tracking state
  logic [1:0]                 hyst_level;
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic [ENV_W-1:0]           envelope;
  logic [IDX_W-1:0]           sample_index;
  logic [IDX_W-1:0]           last_edge_index;
  logic [CNT_W-1:0]           edges_seen;
  logic [PERIOD_W-1:0]        period_estimate;

  // per-item working registers
  logic signed [SAMPLE_W-1:0] cur_sample;
  logic [HI_W-1:0]            hi;
  logic [D_W-1:0]             interval;
  logic                       edge_flag;

  state_t state, state_next;

  mac_ctl_t         mac_ctl;
  logic [ACC_W-1:0] acc;

  aspt_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .acc (acc)
  );

  // magnitude of the current sample, 24 bits holds 2^23
  logic [SAMPLE_W-1:0] mag;
  assign mag = cur_sample[SAMPLE_W-1] ? SAMPLE_W'(-cur_sample) : SAMPLE_W'(cur_sample);

  // envelope after this sample, read straight off the accumulator
  logic [ENV_W-1:0] env_new;
  assign env_new = acc[16 +: ENV_W];

  // high threshold before the floor is applied
  logic [HI_W-1:0] hi_raw;
  logic [HI_W-1:0] hi_sel;
  assign hi_raw = acc[16 + ENV_FRAC_BITS +: HI_W];
  assign hi_sel = (hi_raw < threshold_floor) ? threshold_floor : hi_raw;

  // hysteresis decision, all compares done at 25 bits signed
  logic signed [SAMPLE_W:0] s_x, p_x, hi_x, lo_x;
  logic                     up_edge, down_edge, to_mid_hi, to_mid_lo;
  logic [1:0]               level_next;

  always_comb begin
    s_x  = SAMPLE_W'(cur_sample) == '0 ? '0 : {cur_sample[SAMPLE_W-1], cur_sample};
    p_x  = {previous_sample[SAMPLE_W-1], previous_sample};
    hi_x = {2'b00, hi};
    lo_x = {2'b00, acc[16 +: HI_W]};
    up_edge   = (hyst_level != LVL_HIGH) && (p_x < hi_x) && (s_x >= hi_x);
    down_edge = (hyst_level != LVL_LOW) && (p_x > -hi_x) && (s_x <= -hi_x);
    to_mid_hi = (hyst_level == LVL_HIGH) && (s_x <= lo_x);
    to_mid_lo = (hyst_level == LVL_LOW) && (s_x >= -lo_x);
    if (up_edge) begin
      level_next = LVL_HIGH;
    end else if (down_edge) begin
      level_next = LVL_LOW;
    end else if (to_mid_hi || to_mid_lo) begin
      level_next = LVL_MID;
    end else begin
      level_next = hyst_level;
    end
  end

  logic is_edge;
  assign is_edge = up_edge || down_edge;

  // plausibility window for the edge-to-edge interval
  logic [IDX_W-1:0] d_full;
  logic [D_W-1:0]   rate_x2;
  logic [D_W-1:0]   d_x4000;
  logic             too_long, too_short, take;
  logic             first_load;

  always_comb begin
    d_full   = sample_index - last_edge_index;
    rate_x2  = {sample_rate_hz, 1'b0};
    // 4000*d only matters while d is below 256, beyond that it tops any rate
    d_x4000  = D_W'(d_full[7:0]) * D_W'(4000);
    too_long  = (d_full[IDX_W-1:D_W] != '0) || (d_full[D_W-1:0] > rate_x2);
    too_short = (d_full[IDX_W-1:8] == '0) && (d_x4000 < D_W'(sample_rate_hz));
    take      = is_edge && (edges_seen != '0) && (d_full != '0) && !too_long && !too_short;
    first_load = (period_estimate <= PERIOD_ONE);
  end

  // smoothed period with saturation
  logic [PERIOD_W-1:0] per_smooth;
  assign per_smooth = (acc[ACC_W-1:16+PERIOD_W] != '0) ? '1 : acc[16 +: PERIOD_W];

  // sequencer: next state and multiplier control
  always_comb begin
    state_next    = state;
    mac_ctl       = '0;
    mac_ctl.a     = '0;
    mac_ctl.b     = '0;
    mac_ctl.shift = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          // preload the rounding constant for the envelope update
          mac_ctl.en    = 1'b1;
          mac_ctl.clear = 1'b1;
          mac_ctl.rnd   = 1'b1;
          state_next    = S_ENV_L;
        end
      end
      S_ENV_L: begin
        mac_ctl.en = 1'b1;
        mac_ctl.a  = MUL_A_W'(envelope[ENV_LO_W-1:0]);
        mac_ctl.b  = C_ENV_KEEP;
        state_next = S_ENV_H;
      end
      S_ENV_H: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.a     = MUL_A_W'(envelope[ENV_W-1:ENV_LO_W]);
        mac_ctl.b     = C_ENV_KEEP;
        mac_ctl.shift = SHIFT_W'(ENV_LO_W);
        state_next    = S_ENV_M;
      end
      S_ENV_M: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.a     = MUL_A_W'(mag);
        mac_ctl.b     = C_ENV_NEW;
        mac_ctl.shift = SHIFT_W'(ENV_FRAC_BITS);
        state_next    = S_HI_L;
      end
      S_HI_L: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_ctl.a     = MUL_A_W'(env_new[ENV_LO_W-1:0]);
        mac_ctl.b     = C_HI;
        state_next    = S_HI_H;
      end
      S_HI_H: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.a     = MUL_A_W'(envelope[ENV_W-1:ENV_LO_W]);
        mac_ctl.b     = C_HI;
        mac_ctl.shift = SHIFT_W'(ENV_LO_W);
        state_next    = S_LO;
      end
      S_LO: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_ctl.a     = MUL_A_W'(hi_sel);
        mac_ctl.b     = C_LO;
        state_next    = S_DECIDE;
      end
      S_DECIDE: begin
        if (take && !first_load) begin
          mac_ctl.en    = 1'b1;
          mac_ctl.clear = 1'b1;
          mac_ctl.rnd   = 1'b1;
          mac_ctl.a     = MUL_A_W'(period_estimate);
          mac_ctl.b     = C_PER_KEEP;
          state_next    = S_PER_X;
        end else begin
          state_next = S_OUT;
        end
      end
      S_PER_X: begin
        mac_ctl.en    = 1'b1;
        mac_ctl.a     = MUL_A_W'(interval);
        mac_ctl.b     = C_PER_NEW;
        mac_ctl.shift = SHIFT_W'(PERIOD_FRAC_BITS);
        state_next    = S_PER_WB;
      end
      S_PER_WB: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes, an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate_hz  <= RATE_RESET;
      threshold_floor <= FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_RATE:  sample_rate_hz  <= cfg_data[RATE_W-1:0];
        REG_THRESH_FLOOR: threshold_floor <= cfg_data[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // tracking state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      hyst_level      <= LVL_MID;
      previous_sample <= '0;
      envelope        <= '0;
      sample_index    <= '0;
      last_edge_index <= '0;
      edges_seen      <= '0;
      period_estimate <= '0;
      edge_flag       <= 1'b0;
    end else begin
      case (state)
        S_HI_L: begin
          envelope <= env_new;
        end
        S_DECIDE: begin
          hyst_level      <= level_next;
          edge_flag       <= is_edge;
          previous_sample <= cur_sample;
          sample_index    <= sample_index + IDX_W'(1);
          if (is_edge) begin
            last_edge_index <= sample_index;
            if (edges_seen != '1) begin
              edges_seen <= edges_seen + CNT_W'(1);
            end
          end
          // first accepted interval loads directly, it always fits below 2^20
          if (take && first_load) begin
            period_estimate <= PERIOD_W'(d_full[D_W-1:0]) << PERIOD_FRAC_BITS;
          end
        end
        S_PER_WB: begin
          period_estimate <= per_smooth;
        end
        default: ;
      endcase
    end
  end

  // payload registers of the item in flight
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur_sample <= sample;
    end
    if (state == S_LO) begin
      hi <= hi_sel;
    end
    if (state == S_DECIDE) begin
      interval <= d_full[D_W-1:0];
    end
  end

  // no transfer is taken while reset is held
  assign in_ready   = (state == S_IDLE) && !rst;
  assign out_valid  = (state == S_OUT);
  assign cfg_ready  = !rst;
  assign edge_res   = edge_flag;
  assign level      = hyst_level;
  assign edge_total = edges_seen;
  assign period     = period_estimate;
  assign locked     = (period_estimate > PERIOD_ONE) && (edges_seen >= CNT_W'(2));

endmodule

// ===== rtl/aspt_mac.sv =====
// shared multiply-accumulate unit of the period tracker
// depends on aspt_pkg
module aspt_mac import aspt_pkg::*; (
  input  logic             clk,
  input  mac_ctl_t         ctl,
  output logic [ACC_W-1:0] acc
);

  logic [MUL_A_W+COEF_W-1:0] prod;
  logic [ACC_W-1:0]          term;
  logic [ACC_W-1:0]          base;
  logic [ACC_W-1:0]          acc_next;

  always_comb begin
    prod     = ctl.a * ctl.b;
    term     = ACC_W'(prod) << ctl.shift;
    base     = ctl.clear ? '0 : acc;
    acc_next = base + term + (ctl.rnd ? ACC_W'(32768) : '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= acc_next;
    end
  end

endmodule

// ===== rtl/aspt_checker.sv =====
// port-level checks for the adaptive schmitt period tracker, bound to the top level
// depends on aspt_pkg and adaptive_schmitt_period_tracker_macros.svh
`include "adaptive_schmitt_period_tracker_macros.svh"

module aspt_checker import aspt_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       edge_res,
  input logic signed [1:0]          level,
  input logic [CNT_W-1:0]           edge_total,
  input logic [PERIOD_W-1:0]        period,
  input logic                       locked
);

  // one sample in flight: after an input transfer nothing is offered or taken
  `ASPT_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready && !out_valid)

  `ASPT_ASSERT_ALWAYS(a_one_side, !(in_ready && out_valid))

  // an edge always leaves the level at high or low
  `ASPT_ASSERT_ALWAYS(a_edge_level, !(out_valid && edge_res) || (level != LVL_MID))

  `ASPT_ASSERT_ALWAYS(a_lock_count, !(out_valid && locked) || (edge_total >= CNT_W'(2)))

  `ASPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(edge_total) && $stable(period))

endmodule

bind adaptive_schmitt_period_tracker aspt_checker u_aspt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .edge_res   (edge_res),
  .level      (level),
  .edge_total (edge_total),
  .period     (period),
  .locked     (locked)
);
